@@ rtl/servo_pose_record_playback_unit_macros.svh @@
`ifndef SERVO_POSE_RECORD_PLAYBACK_UNIT_MACROS_SVH
`define SERVO_POSE_RECORD_PLAYBACK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo pose unit assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SPR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo pose unit assertion failed");

`endif

@@ rtl/spr_pkg.sv @@
package spr_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_MODE = 2'd1,
        CMD_SAVE = 2'd2,
        CMD_PLAY = 2'd3
    } cmd_t;

    localparam logic [15:0] DWELL_RESET = 16'd350;

    typedef struct packed {
        logic [14:0] a;
        logic [14:0] b;
        logic [7:0]  c;
        logic [7:0]  d;
    } pose_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] cur_a;
        logic [15:0] cur_b;
        logic [7:0]  cur_c;
        logic [7:0]  cur_d;
    } item_t;

    typedef struct packed {
        logic        active_mode;
        logic        playing;
        logic        apply_pose;
        logic [15:0] out_a;
        logic [15:0] out_b;
        logic [7:0]  out_c;
        logic [7:0]  out_d;
        logic        saved;
        logic [1:0]  saved_slot;
    } result_t;

endpackage

@@ rtl/servo_pose_record_playback_unit.sv @@
// Channel   | Handshake              | Contents
// request   | cmd_valid / cmd_ready  | command, cur_a, cur_b, cur_c, cur_d
// result    | res_valid / res_ready  | active_mode, playing, apply_pose, out_a..out_d, saved,
//           |                        | saved_slot
// config    | dwell_we               | dwell_wdata (dwell_ticks)
//
// Each request is held in an input register and resolved into the result register once that
// register is empty or its result is being taken.
// One request is accepted every cycle while results are taken; the single combinational
// pass between the two registers, with one read of the pose file, sets that rate.
// The result register lets a new request enter while a finished result waits to be taken.
// When res_ready stays low the result and the held request both stall, and cmd_ready drops.
// Reset clears the control state and sets the dwell to 350; the pose file is not cleared.
module servo_pose_record_playback_unit #(
    parameter int SLOTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dwell_we,
    input  logic [15:0] dwell_wdata,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  command,
    input  logic [15:0] cur_a,
    input  logic [15:0] cur_b,
    input  logic [7:0]  cur_c,
    input  logic [7:0]  cur_d,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        active_mode,
    output logic        playing,
    output logic        apply_pose,
    output logic [15:0] out_a,
    output logic [15:0] out_b,
    output logic [7:0]  out_c,
    output logic [7:0]  out_d,
    output logic        saved,
    output logic [1:0]  saved_slot
);

    `include "servo_pose_record_playback_unit_macros.svh"

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    spr_pkg::item_t   item_reg;
    logic             in_valid_reg;
    spr_pkg::result_t res_reg;
    logic             res_valid_reg;

    logic             advance;
    spr_pkg::result_t result;
    spr_pkg::pose_t   rd_pose;
    spr_pkg::pose_t   wr_pose;
    logic             rd_bank;
    logic [SW-1:0]    rd_slot;
    logic             wr_en;
    logic             wr_bank;
    logic [SW-1:0]    wr_slot;

    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                in_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg.command <= spr_pkg::cmd_t'(command);
            item_reg.cur_a   <= cur_a;
            item_reg.cur_b   <= cur_b;
            item_reg.cur_c   <= cur_c;
            item_reg.cur_d   <= cur_d;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    spr_engine #(
        .SLOTS (SLOTS),
        .SW    (SW),
        .CW    (CW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .dwell_we    (dwell_we),
        .dwell_wdata (dwell_wdata),
        .commit      (advance),
        .item        (item_reg),
        .rd_pose     (rd_pose),
        .rd_bank     (rd_bank),
        .rd_slot     (rd_slot),
        .wr_en       (wr_en),
        .wr_bank     (wr_bank),
        .wr_slot     (wr_slot),
        .wr_pose     (wr_pose),
        .result      (result)
    );

    spr_pose_regs #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_pose_regs (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_bank (wr_bank),
        .wr_slot (wr_slot),
        .wr_pose (wr_pose),
        .rd_bank (rd_bank),
        .rd_slot (rd_slot),
        .rd_pose (rd_pose)
    );

    assign res_valid   = res_valid_reg;
    assign active_mode = res_reg.active_mode;
    assign playing     = res_reg.playing;
    assign apply_pose  = res_reg.apply_pose;
    assign out_a       = res_reg.out_a;
    assign out_b       = res_reg.out_b;
    assign out_c       = res_reg.out_c;
    assign out_d       = res_reg.out_d;
    assign saved       = res_reg.saved;
    assign saved_slot  = res_reg.saved_slot;

    `SPR_ASSERT_NXT(a_advance_loads_result, advance, res_valid_reg)
    `SPR_ASSERT_IMP(a_empty_input_ready, !in_valid_reg, cmd_ready)
    `SPR_ASSERT_IMP(a_pose_while_playing, res_valid_reg && res_reg.apply_pose,
                    res_reg.playing && !res_reg.saved)

endmodule

@@ rtl/spr_pose_regs.sv @@
module spr_pose_regs #(
    parameter int SLOTS = 4,
    parameter int SW    = 2
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic            wr_bank,
    input  logic [SW-1:0]   wr_slot,
    input  spr_pkg::pose_t  wr_pose,
    input  logic            rd_bank,
    input  logic [SW-1:0]   rd_slot,
    output spr_pkg::pose_t  rd_pose
);

    spr_pkg::pose_t pose_reg [0:1][0:SLOTS-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pose_reg[wr_bank][wr_slot] <= wr_pose;
        end
    end

    assign rd_pose = pose_reg[rd_bank][rd_slot];

endmodule

@@ rtl/spr_engine.sv @@
module spr_engine #(
    parameter int SLOTS = 4,
    parameter int SW    = 2,
    parameter int CW    = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dwell_we,
    input  logic [15:0]       dwell_wdata,
    input  logic              commit,
    input  spr_pkg::item_t    item,
    input  spr_pkg::pose_t    rd_pose,
    output logic              rd_bank,
    output logic [SW-1:0]     rd_slot,
    output logic              wr_en,
    output logic              wr_bank,
    output logic [SW-1:0]     wr_slot,
    output spr_pkg::pose_t    wr_pose,
    output spr_pkg::result_t  result
);

    `include "servo_pose_record_playback_unit_macros.svh"

    logic [15:0]   dwell_reg;
    logic          mode_reg,  mode_next;
    logic          play_reg,  play_next;
    logic [SW-1:0] wslot_reg [0:1];
    logic [SW-1:0] wslot_next [0:1];
    logic [CW-1:0] count_reg [0:1];
    logic [CW-1:0] count_next [0:1];
    logic [CW-1:0] pslot_reg, pslot_next;
    logic [15:0]   tick_reg,  tick_next;

    logic          bank;
    logic [CW-1:0] cnt;
    logic [SW-1:0] ws;
    logic [SW+1:0] ws_ext;
    logic [15:0]   tick_inc;

    assign bank     = mode_reg;
    assign cnt      = count_reg[bank];
    assign ws       = wslot_reg[bank];
    assign ws_ext   = {2'b00, ws};
    assign tick_inc = tick_reg + 16'd1;

    assign rd_bank = bank;
    assign rd_slot = pslot_reg[SW-1:0];

    assign wr_bank      = bank;
    assign wr_slot      = ws;
    assign wr_pose.a    = item.cur_a[15:1];
    assign wr_pose.b    = item.cur_b[15:1];
    assign wr_pose.c    = item.cur_c;
    assign wr_pose.d    = item.cur_d;

    always_comb
    begin
        mode_next  = mode_reg;
        play_next  = play_reg;
        wslot_next = wslot_reg;
        count_next = count_reg;
        pslot_next = pslot_reg;
        tick_next  = tick_reg;
        wr_en      = 1'b0;
        result     = '0;

        unique case (item.command)
            spr_pkg::CMD_TICK:
            begin
                if (play_reg)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= dwell_reg)
                    begin
                        tick_next = '0;
                        if ((pslot_reg >= cnt) || (pslot_reg >= CW'(SLOTS)))
                        begin
                            pslot_next = '0;
                            play_next  = 1'b0;
                        end
                        else
                        begin
                            result.apply_pose = 1'b1;
                            result.out_a      = {rd_pose.a, 1'b0};
                            result.out_b      = {rd_pose.b, 1'b0};
                            result.out_c      = rd_pose.c;
                            result.out_d      = rd_pose.d;
                            pslot_next        = pslot_reg + CW'(1);
                        end
                    end
                end
            end
            spr_pkg::CMD_MODE:
            begin
                mode_next = ~mode_reg;
            end
            spr_pkg::CMD_SAVE:
            begin
                wr_en             = commit;
                result.saved      = 1'b1;
                result.saved_slot = ws_ext[1:0];
                if (ws_ext >= (SW+2)'(SLOTS - 1))
                begin
                    wslot_next[bank] = '0;
                end
                else
                begin
                    wslot_next[bank] = ws + SW'(1);
                end
                if (cnt < CW'(SLOTS))
                begin
                    count_next[bank] = cnt + CW'(1);
                end
            end
            spr_pkg::CMD_PLAY:
            begin
                if (cnt != '0)
                begin
                    play_next  = 1'b1;
                    pslot_next = '0;
                    tick_next  = '0;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        result.active_mode = mode_next;
        result.playing     = play_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg  <= spr_pkg::DWELL_RESET;
            mode_reg   <= 1'b0;
            play_reg   <= 1'b0;
            wslot_reg  <= '{default: '0};
            count_reg  <= '{default: '0};
            pslot_reg  <= '0;
            tick_reg   <= '0;
        end
        else
        begin
            if (dwell_we)
            begin
                dwell_reg <= dwell_wdata;
            end
            if (commit)
            begin
                mode_reg  <= mode_next;
                play_reg  <= play_next;
                wslot_reg <= wslot_next;
                count_reg <= count_next;
                pslot_reg <= pslot_next;
                tick_reg  <= tick_next;
            end
        end
    end

    `SPR_ASSERT_IMP(a_play_needs_entries, $rose(play_reg), count_reg[mode_reg] != '0)
    `SPR_ASSERT_NXT(a_save_counts, commit && (item.command == spr_pkg::CMD_SAVE), count_reg[$past(mode_reg)] != '0)
    `SPR_ASSERT_IMP(a_play_slot_bound, play_reg, pslot_reg <= CW'(SLOTS))

endmodule

@@ verif/servo_pose_record_playback_unit_checker.sv @@
`timescale 1ns / 100ps

module servo_pose_record_playback_unit_checker #(
    parameter int SLOTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dwell_we,
    input  logic [15:0] dwell_wdata,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  logic [1:0]  command,
    input  logic [15:0] cur_a,
    input  logic [15:0] cur_b,
    input  logic [7:0]  cur_c,
    input  logic [7:0]  cur_d,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic        active_mode,
    input  logic        playing,
    input  logic        apply_pose,
    input  logic [15:0] out_a,
    input  logic [15:0] out_b,
    input  logic [7:0]  out_c,
    input  logic [7:0]  out_d,
    input  logic        saved,
    input  logic [1:0]  saved_slot,
    output int          failures,
    output int          awaited
);

    logic [15:0]      dwell;
    logic             mode;
    logic             running;
    logic [15:0]      tick_total;
    int               replay_slot;
    int               next_slot [2];
    int               held_count [2];
    spr_pkg::pose_t   pose_bank [2][SLOTS];
    spr_pkg::result_t awaited_results [$];

    task automatic report(input string msg);
        if (failures < 100)
            $display("%0t ns servo checker: %s", $time, msg);
        failures = failures + 1;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    task automatic predict_request(input spr_pkg::cmd_t op, input logic [15:0] a,
                                   input logic [15:0] b, input logic [7:0] c,
                                   input logic [7:0] d, output spr_pkg::result_t res);
        int             bank;
        int             slot;
        spr_pkg::pose_t pose;
        res = '0;
        bank = int'(mode);
        case (op)
            spr_pkg::CMD_TICK:
            begin
                if (running)
                begin
                    tick_total = tick_total + 16'd1;
                    if (tick_total >= dwell)
                    begin
                        tick_total = '0;
                        if (replay_slot >= held_count[bank] || replay_slot >= SLOTS)
                        begin
                            replay_slot = 0;
                            running = 1'b0;
                        end
                        else
                        begin
                            pose = pose_bank[bank][replay_slot];
                            res.apply_pose = 1'b1;
                            res.out_a = {pose.a, 1'b0};
                            res.out_b = {pose.b, 1'b0};
                            res.out_c = pose.c;
                            res.out_d = pose.d;
                            replay_slot = replay_slot + 1;
                        end
                    end
                end
            end
            spr_pkg::CMD_MODE:
            begin
                mode = ~mode;
            end
            spr_pkg::CMD_SAVE:
            begin
                slot = next_slot[bank];
                pose.a = a[15:1];
                pose.b = b[15:1];
                pose.c = c;
                pose.d = d;
                pose_bank[bank][slot] = pose;
                res.saved = 1'b1;
                res.saved_slot = slot[1:0];
                next_slot[bank] = (slot + 1 >= SLOTS) ? 0 : slot + 1;
                if (held_count[bank] < SLOTS)
                    held_count[bank] = held_count[bank] + 1;
            end
            default:
            begin
                if (held_count[bank] > 0)
                begin
                    running = 1'b1;
                    replay_slot = 0;
                    tick_total = '0;
                end
            end
        endcase
        res.active_mode = mode;
        res.playing = running;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        spr_pkg::result_t predicted;
        spr_pkg::result_t oldest;
        if (!rst_n)
        begin
            dwell = spr_pkg::DWELL_RESET;
            mode = 1'b0;
            running = 1'b0;
            tick_total = '0;
            replay_slot = 0;
            next_slot[0] = 0;
            next_slot[1] = 0;
            held_count[0] = 0;
            held_count[1] = 0;
            awaited_results.delete();
            failures = 0;
            awaited = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report("result arrived with no request outstanding");
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    check_field("active_mode", active_mode, oldest.active_mode);
                    check_field("playing", playing, oldest.playing);
                    check_field("apply_pose", apply_pose, oldest.apply_pose);
                    check_field("out_a", out_a, oldest.out_a);
                    check_field("out_b", out_b, oldest.out_b);
                    check_field("out_c", out_c, oldest.out_c);
                    check_field("out_d", out_d, oldest.out_d);
                    check_field("saved", saved, oldest.saved);
                    check_field("saved_slot", saved_slot, oldest.saved_slot);
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                predict_request(spr_pkg::cmd_t'(command), cur_a, cur_b, cur_c, cur_d,
                                predicted);
                awaited_results.push_back(predicted);
            end
            if (dwell_we)
                dwell = dwell_wdata;
            awaited = awaited_results.size();
        end
    end

endmodule

@@ verif/servo_pose_record_playback_unit_test.sv @@
`timescale 1ns / 100ps

module servo_pose_record_playback_unit_test;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        dwell_we;
    logic [15:0] dwell_wdata;
    logic        cmd_valid;
    logic        cmd_ready;
    logic [1:0]  command;
    logic [15:0] cur_a;
    logic [15:0] cur_b;
    logic [7:0]  cur_c;
    logic [7:0]  cur_d;
    logic        res_valid;
    logic        res_ready;
    logic        active_mode;
    logic        playing;
    logic        apply_pose;
    logic [15:0] out_a;
    logic [15:0] out_b;
    logic [7:0]  out_c;
    logic [7:0]  out_d;
    logic        saved;
    logic [1:0]  saved_slot;
    int          failures;
    int          awaited;
    int          idle_mode = 0;
    int          cycle_count = 0;

    servo_pose_record_playback_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .dwell_we    (dwell_we),
        .dwell_wdata (dwell_wdata),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .cur_a       (cur_a),
        .cur_b       (cur_b),
        .cur_c       (cur_c),
        .cur_d       (cur_d),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .active_mode (active_mode),
        .playing     (playing),
        .apply_pose  (apply_pose),
        .out_a       (out_a),
        .out_b       (out_b),
        .out_c       (out_c),
        .out_d       (out_d),
        .saved       (saved),
        .saved_slot  (saved_slot)
    );

    servo_pose_record_playback_unit_checker pose_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .dwell_we    (dwell_we),
        .dwell_wdata (dwell_wdata),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .cur_a       (cur_a),
        .cur_b       (cur_b),
        .cur_c       (cur_c),
        .cur_d       (cur_d),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .active_mode (active_mode),
        .playing     (playing),
        .apply_pose  (apply_pose),
        .out_a       (out_a),
        .out_b       (out_b),
        .out_c       (out_c),
        .out_d       (out_d),
        .saved       (saved),
        .saved_slot  (saved_slot),
        .failures    (failures),
        .awaited     (awaited)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int idle_percent(input bit receiver);
        case (idle_mode)
            0: return receiver ? 76 : 38;
            1: return receiver ? 38 : 76;
            default: return 0;
        endcase
    endfunction

    always @(negedge clk)
        res_ready <= ($urandom_range(99) >= idle_percent(1'b1));

    function automatic logic [15:0] edge_value(input int bits);
        logic [15:0] mask;
        mask = 16'((32'd1 << bits) - 32'd1);
        case ($urandom_range(7))
            0: return 16'd0;
            1: return mask;
            default: return 16'($urandom) & mask;
        endcase
    endfunction

    task automatic send_request(input spr_pkg::cmd_t op, input logic [15:0] a,
                                input logic [15:0] b, input logic [7:0] c,
                                input logic [7:0] d);
        while ($urandom_range(99) < idle_percent(1'b0))
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        command = op;
        cur_a = a;
        cur_b = b;
        cur_c = c;
        cur_d = d;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_request(spr_pkg::CMD_TICK, edge_value(16), edge_value(16),
                     8'(edge_value(8)), 8'(edge_value(8)));
    endtask

    task automatic random_requests(input int count);
        spr_pkg::cmd_t op;
        int            pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 52)
                op = spr_pkg::CMD_TICK;
            else if (pick < 70)
                op = spr_pkg::CMD_SAVE;
            else if (pick < 80)
                op = spr_pkg::CMD_MODE;
            else
                op = spr_pkg::CMD_PLAY;
            send_request(op, edge_value(16), edge_value(16), 8'(edge_value(8)),
                         8'(edge_value(8)));
        end
    endtask

    task automatic settle_block();
        cmd_valid = 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_dwell(input logic [15:0] value);
        settle_block();
        dwell_we = 1'b1;
        dwell_wdata = value;
        @(negedge clk);
        dwell_we = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        dwell_we = 1'b0;
        dwell_wdata = '0;
        cmd_valid = 1'b0;
        command = spr_pkg::CMD_TICK;
        cur_a = '0;
        cur_b = '0;
        cur_c = '0;
        cur_d = '0;
        res_ready = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The reset dwell holds: one pose comes out on the 350th tick.
        send_tick();
        send_request(spr_pkg::CMD_PLAY, 16'h1234, 16'h4321, 8'h12, 8'h21);
        send_request(spr_pkg::CMD_SAVE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(spr_pkg::CMD_PLAY, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(spr_pkg::CMD_MODE, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(spr_pkg::CMD_PLAY, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(spr_pkg::CMD_MODE, 16'h0000, 16'h0000, 8'h00, 8'h00);
        repeat (352) send_tick();

        write_dwell(16'd1);
        send_tick();
        send_tick();
        send_request(spr_pkg::CMD_MODE, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(spr_pkg::CMD_PLAY, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(spr_pkg::CMD_SAVE, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(spr_pkg::CMD_SAVE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(spr_pkg::CMD_SAVE, 16'hAAAA, 16'h5555, 8'hAA, 8'h55);
        send_request(spr_pkg::CMD_SAVE, 16'h5555, 16'hAAAA, 8'h55, 8'hAA);
        send_request(spr_pkg::CMD_SAVE, 16'h0001, 16'h8000, 8'h01, 8'h80);
        send_request(spr_pkg::CMD_PLAY, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_tick();
        send_request(spr_pkg::CMD_SAVE, 16'h7FFF, 16'hFFFE, 8'h7F, 8'hFE);
        send_tick();
        send_request(spr_pkg::CMD_MODE, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_tick();
        send_request(spr_pkg::CMD_PLAY, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(spr_pkg::CMD_PLAY, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_tick();
        send_tick();
        send_request(spr_pkg::CMD_MODE, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(spr_pkg::CMD_PLAY, 16'h0000, 16'h0000, 8'h00, 8'h00);
        repeat (5) send_tick();

        write_dwell(16'd0);
        random_requests(60);

        idle_mode = 1;
        write_dwell(16'd2);
        random_requests(80);
        write_dwell(16'hFFFF);
        random_requests(20);
        write_dwell(16'd1);
        random_requests(100);

        idle_mode = 2;
        write_dwell(16'($urandom_range(3, 8)));
        random_requests(110);
        write_dwell(16'd3);
        random_requests(95);

        settle_block();
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_pose_regs.sv
rtl/spr_engine.sv
rtl/servo_pose_record_playback_unit.sv
verif/servo_pose_record_playback_unit_checker.sv
verif/servo_pose_record_playback_unit_test.sv
